// ----- design/fork_grant_arbiter_top_macros.svh -----
// Assertion helpers for the fork grant arbiter.
// Every assertion uses clk_i and is disabled while rst_ni is low.
`ifndef FORK_GRANT_ARBITER_TOP_MACROS_SVH
`define FORK_GRANT_ARBITER_TOP_MACROS_SVH

`define FGA_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define FGA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fga_pkg.sv -----
`default_nettype none

package fga_pkg;

  localparam int unsigned MaxSeatsDef = 16;
  localparam int unsigned SeatsReset  = 5;

  localparam int unsigned CfgW  = 5;
  localparam int unsigned SeatW = 4;
  localparam int unsigned ActW  = 2;

  localparam logic [ActW-1:0] ActLeft  = 2'd0;
  localparam logic [ActW-1:0] ActRight = 2'd1;
  localparam logic [ActW-1:0] ActPut   = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan;
    logic load0;
    logic load1;
  } cmd_t;

  typedef struct packed {
    logic in_want;
    logic in_put;
    logic can;
    logic queue_empty;
    logic scan_last;
    logic scan_grant;
    logic k_nz;
    logic two;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- design/fga_ctrl.sv -----
`default_nettype none

module fga_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire fga_pkg::status_t status_i,
  output fga_pkg::cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StEmit0,
    StEmit1
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (status_i.in_want && status_i.can) begin
            state_d = StEmit0;
          end else if (status_i.in_put && !status_i.queue_empty) begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = (status_i.k_nz || status_i.scan_grant) ? StEmit0 : StIdle;
        end
      end
      StEmit0: begin
        if (status_i.out_free) begin
          cmd_o.load0 = 1'b1;
          state_d     = status_i.two ? StEmit1 : StIdle;
        end
      end
      StEmit1: begin
        if (status_i.out_free) begin
          cmd_o.load1 = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

`default_nettype wire

// ----- design/fga_datapath.sv -----
`default_nettype none

`include "fork_grant_arbiter_top_macros.svh"

module fga_datapath #(
  parameter int unsigned MAX_SEATS = fga_pkg::MaxSeatsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_wr_en_i,
  input  wire logic [fga_pkg::CfgW-1:0]    cfg_wr_data_i,
  input  wire logic [fga_pkg::ActW-1:0]    action_i,
  input  wire logic [fga_pkg::SeatW-1:0]   seat_i,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output logic [fga_pkg::SeatW-1:0]        granted_seat_o,
  output logic                             fork_side_o,
  output logic                             last_o,
  input  wire fga_pkg::cmd_t               cmd_i,
  output fga_pkg::status_t                 status_o
);

  localparam int unsigned FW    = $clog2(MAX_SEATS);
  localparam int unsigned NW    = $clog2(MAX_SEATS + 1);
  localparam int unsigned Depth = MAX_SEATS - 1;
  localparam int unsigned QW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned EW    = fga_pkg::SeatW + 1;

  function automatic logic [QW-1:0] q_inc(input logic [QW-1:0] p);
    return (p == QW'(Depth - 1)) ? '0 : p + QW'(1);
  endfunction

  logic [fga_pkg::CfgW-1:0] num_seats_q;
  logic [MAX_SEATS-1:0]     busy_q, busy_d;
  logic [NW-1:0]            taken_q, taken_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            scan_left_q, scan_left_d;
  logic [QW-1:0]            head_q, head_d;
  logic [QW-1:0]            tail_q, tail_d;
  logic [1:0]               k_q, k_d;
  logic                     out_valid_q, out_valid_d;

  logic [EW-1:0]            wait_mem_q [Depth];
  logic [EW-1:0]            rd_data_q;
  logic [EW-1:0]            g0_q, g1_q;
  logic [fga_pkg::SeatW-1:0] out_seat_q;
  logic                     out_side_q, out_last_q;

  logic [NW-1:0]             n;
  logic                      chk_side;
  logic [fga_pkg::SeatW-1:0] chk_seat;
  logic [EW-1:0]             entry_chk;
  logic                      seat_ok, room_ok, can;
  logic [31:0]               right_sum;
  logic [FW-1:0]             f_left, f_right, f_sel;
  logic                      in_want, in_put;
  logic                      do_grant, do_push_new, do_put, do_rotate, mem_we;
  logic [QW-1:0]             rd_addr;
  logic                      out_free, out_load;

  always_comb begin
    if (num_seats_q < fga_pkg::CfgW'(2)) begin
      n = NW'(2);
    end else if (32'(num_seats_q) > MAX_SEATS) begin
      n = NW'(MAX_SEATS);
    end else begin
      n = NW'(num_seats_q);
    end
  end

  assign chk_side  = cmd_i.scan ? rd_data_q[EW-1] : action_i[0];
  assign chk_seat  = cmd_i.scan ? rd_data_q[fga_pkg::SeatW-1:0] : seat_i;
  assign entry_chk = {chk_side, chk_seat};

  assign seat_ok   = (32'(chk_seat) < 32'(n));
  assign right_sum = 32'(chk_seat) + 32'd1;
  assign f_left    = FW'(chk_seat);
  assign f_right   = (right_sum == 32'(n)) ? '0 : FW'(right_sum);
  assign f_sel     = chk_side ? f_right : f_left;
  assign room_ok   = chk_side || ((32'(taken_q) + 32'd1) < 32'(n));
  assign can       = seat_ok && room_ok && !busy_q[f_sel];

  assign in_want = (action_i == fga_pkg::ActLeft) || (action_i == fga_pkg::ActRight);
  assign in_put  = (action_i == fga_pkg::ActPut) && seat_ok;

  assign do_grant    = (cmd_i.accept && in_want && can) || (cmd_i.scan && can && !k_q[1]);
  assign do_push_new = cmd_i.accept && in_want && !can && seat_ok && (count_q != CW'(Depth));
  assign do_put      = cmd_i.accept && in_put;
  assign do_rotate   = cmd_i.scan && !do_grant;
  assign mem_we      = do_push_new || do_rotate;
  assign rd_addr     = cmd_i.scan ? q_inc(head_q) : head_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.load0 || cmd_i.load1;

  always_comb begin
    busy_d      = busy_q;
    taken_d     = taken_q;
    count_d     = count_q;
    scan_left_d = scan_left_q;
    head_d      = head_q;
    tail_d      = tail_q;
    k_d         = k_q;
    if (do_put) begin
      busy_d[f_left]  = 1'b0;
      busy_d[f_right] = 1'b0;
      taken_d         = (taken_q >= NW'(2)) ? taken_q - NW'(2) : '0;
      k_d             = '0;
      scan_left_d     = count_q;
    end
    if (do_grant) begin
      busy_d[f_sel] = 1'b1;
      if (32'(taken_q) < MAX_SEATS) begin
        taken_d = taken_q + NW'(1);
      end
      k_d = cmd_i.accept ? 2'd1 : k_q + 2'd1;
    end
    if (do_push_new) begin
      tail_d  = q_inc(tail_q);
      count_d = count_q + CW'(1);
    end
    if (cmd_i.scan) begin
      head_d      = q_inc(head_q);
      scan_left_d = scan_left_q - CW'(1);
      if (do_grant) begin
        count_d = count_q - CW'(1);
      end else begin
        tail_d = q_inc(tail_q);
      end
    end
  end

  always_comb begin
    out_valid_d = out_load ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seats_q <= fga_pkg::CfgW'(fga_pkg::SeatsReset);
      busy_q      <= '0;
      taken_q     <= '0;
      count_q     <= '0;
      scan_left_q <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        num_seats_q <= cfg_wr_data_i;
      end
      busy_q      <= busy_d;
      taken_q     <= taken_d;
      count_q     <= count_d;
      scan_left_q <= scan_left_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wait_mem_q[tail_q] <= entry_chk;
    end
    rd_data_q <= wait_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (do_grant) begin
      if (cmd_i.accept || (k_q == 2'd0)) begin
        g0_q <= entry_chk;
      end else begin
        g1_q <= entry_chk;
      end
    end
    if (cmd_i.load0) begin
      out_seat_q <= g0_q[fga_pkg::SeatW-1:0];
      out_side_q <= g0_q[EW-1];
      out_last_q <= !k_q[1];
    end else if (cmd_i.load1) begin
      out_seat_q <= g1_q[fga_pkg::SeatW-1:0];
      out_side_q <= g1_q[EW-1];
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_seat_o = out_seat_q;
  assign fork_side_o    = out_side_q;
  assign last_o         = out_last_q;

  always_comb begin
    status_o             = '0;
    status_o.in_want     = in_want;
    status_o.in_put      = in_put;
    status_o.can         = can;
    status_o.queue_empty = (count_q == '0);
    status_o.scan_last   = (scan_left_q == CW'(1));
    status_o.scan_grant  = do_grant;
    status_o.k_nz        = (k_q != 2'd0);
    status_o.two         = k_q[1];
    status_o.out_free    = out_free;
  end

  `FGA_ASSERT(a_count_bound, 1'b1, count_q <= CW'(Depth), "Wait queue count overflow.")
  `FGA_ASSERT(a_taken_bound, 1'b1, 32'(taken_q) <= MAX_SEATS, "Taken count out of range.")
  `FGA_ASSERT(a_grant_cap, 1'b1, k_q != 2'd3, "More than two grants for one request.")
  `FGA_ASSERT(a_load_free, cmd_i.load0 || cmd_i.load1, out_free, "Output overwritten.")
  `FGA_ASSERT_NXT(a_want_grant, cmd_i.accept && in_want && can, k_q == 2'd1, "Lost grant.")

endmodule

`default_nettype wire

// ----- design/fork_grant_arbiter_top.sv -----
// Fork grant arbiter for a ring of seats sharing forks.
// Input channel (in_valid_i, in_stall_o, action_i, seat_i): one request per item,
// accepted when in_valid_i is high and in_stall_o is low. Output channel
// (out_valid_o, out_stall_i, granted_seat_o, fork_side_o, last_o): one item per
// grant, last_o marks the final grant caused by a request.
// The seat count register is written through cfg_wr_en_i and cfg_wr_data_i.
// A request that is ignored or queued is done in the idle state. A granted fork
// request passes the emit step; its grant is held in a grant register and then
// loaded into the output register. A put-back with requests queued first scans
// them all, because the wait queue memory is rotated one entry per cycle; each
// grant then takes an emit step.
// While the receiver stalls, the output register holds its grant; a further grant
// waits in the emit step, which holds off the next request.
// Reset frees all forks, empties the queue and sets the seat count to five; the
// queue memory needs no clearing pass.
`default_nettype none

module fork_grant_arbiter_top #(
  parameter int unsigned MAX_SEATS = fga_pkg::MaxSeatsDef
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_wr_en_i,
  input  wire logic [fga_pkg::CfgW-1:0]    cfg_wr_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [fga_pkg::ActW-1:0]    action_i,
  input  wire logic [fga_pkg::SeatW-1:0]   seat_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [fga_pkg::SeatW-1:0]        granted_seat_o,
  output logic                             fork_side_o,
  output logic                             last_o
);

  fga_pkg::cmd_t    cmd;
  fga_pkg::status_t status;

  fga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fga_datapath #(
    .MAX_SEATS (MAX_SEATS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .action_i       (action_i),
    .seat_i         (seat_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .granted_seat_o (granted_seat_o),
    .fork_side_o    (fork_side_o),
    .last_o         (last_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb_fork_grant_arbiter_top.sv -----
`default_nettype none

module tb_fork_grant_arbiter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkPeriod     = 4;
  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned DrainCycles   = 40;
  localparam int unsigned HoldCycles    = 250;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned QueueDepth    = fga_pkg::MaxSeatsDef - 1;
  localparam int unsigned GrantCap      = 2;
  localparam int unsigned PhaseItems    = 175;

  localparam logic [fga_pkg::ActW-1:0] ActNone = 2'd3;

  typedef struct packed {
    logic [fga_pkg::SeatW-1:0] seat;
    logic                      side;
    logic                      last;
  } grant_t;

  typedef struct packed {
    logic                      side;
    logic [fga_pkg::SeatW-1:0] seat;
  } waiter_t;

  class fork_scoreboard;
    logic [fga_pkg::MaxSeatsDef-1:0] fork_busy;
    int unsigned                     taken;
    logic [fga_pkg::CfgW-1:0]        seats_reg;
    waiter_t                         waiting[$];
    grant_t                          expected_grants[$];
    int unsigned                     failures;

    function new();
      fork_busy = '0;
      taken     = 0;
      seats_reg = fga_pkg::CfgW'(fga_pkg::SeatsReset);
      failures  = 0;
    endfunction

    function void set_seats(logic [fga_pkg::CfgW-1:0] value);
      seats_reg = value;
    endfunction

    function int unsigned ring_size();
      if (seats_reg < 2) return 2;
      if (seats_reg > fga_pkg::MaxSeatsDef) return fga_pkg::MaxSeatsDef;
      return seats_reg;
    endfunction

    function int unsigned next_fork(int unsigned seat_v, int unsigned n);
      return (seat_v + 1 == n) ? 0 : seat_v + 1;
    endfunction

    function bit take_fork(logic side_v, logic [fga_pkg::SeatW-1:0] seat_v);
      int unsigned n;
      int unsigned f;
      n = ring_size();
      if (seat_v >= n) return 1'b0;
      if (side_v == 1'b0) begin
        f = seat_v;
        if (taken + 1 >= n) return 1'b0;
      end else begin
        f = next_fork(seat_v, n);
      end
      if (fork_busy[f]) return 1'b0;
      fork_busy[f] = 1'b1;
      if (taken < fga_pkg::MaxSeatsDef) taken++;
      return 1'b1;
    endfunction

    function void note_request(logic [fga_pkg::ActW-1:0] act,
                               logic [fga_pkg::SeatW-1:0] seat_v);
      int unsigned n;
      int unsigned i;
      int unsigned k;
      logic        side_v;
      waiter_t     w;
      n = ring_size();
      if (act == ActNone || seat_v >= n) return;
      if (act == fga_pkg::ActLeft || act == fga_pkg::ActRight) begin
        side_v = (act == fga_pkg::ActRight);
        if (take_fork(side_v, seat_v)) begin
          expected_grants.push_back('{seat: seat_v, side: side_v, last: 1'b1});
        end else if (waiting.size() < QueueDepth) begin
          waiting.push_back('{side: side_v, seat: seat_v});
        end
        return;
      end
      fork_busy[seat_v] = 1'b0;
      fork_busy[next_fork(seat_v, n)] = 1'b0;
      taken = (taken >= 2) ? taken - 2 : 0;
      i = 0;
      k = 0;
      while (i < waiting.size() && k < GrantCap) begin
        w = waiting[i];
        if (take_fork(w.side, w.seat)) begin
          expected_grants.push_back('{seat: w.seat, side: w.side, last: 1'b0});
          waiting.delete(i);
          k++;
        end else begin
          i++;
        end
      end
      if (k > 0) expected_grants[expected_grants.size() - 1].last = 1'b1;
    endfunction

    function void check_grant(logic [fga_pkg::SeatW-1:0] seat_v, logic side_v,
                              logic last_v);
      grant_t exp_g;
      if (expected_grants.size() == 0) begin
        $error("unexpected grant: granted_seat %0d fork_side %0d last %0d",
               seat_v, side_v, last_v);
        failures++;
        return;
      end
      exp_g = expected_grants.pop_front();
      if (seat_v !== exp_g.seat) begin
        $error("granted_seat: expected %0d, actual %0d", exp_g.seat, seat_v);
        failures++;
      end
      if (side_v !== exp_g.side) begin
        $error("fork_side: expected %0d, actual %0d", exp_g.side, side_v);
        failures++;
      end
      if (last_v !== exp_g.last) begin
        $error("last: expected %0d, actual %0d", exp_g.last, last_v);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      cfg_wr_en   = 1'b0;
  logic [fga_pkg::CfgW-1:0]  cfg_wr_data = '0;
  logic                      in_valid    = 1'b0;
  logic [fga_pkg::ActW-1:0]  action      = fga_pkg::ActLeft;
  logic [fga_pkg::SeatW-1:0] seat        = '0;
  logic                      out_stall   = 1'b0;
  logic                      hold_active = 1'b0;
  wire                       in_stall;
  wire                       out_valid;
  wire [fga_pkg::SeatW-1:0]  granted_seat;
  wire                       fork_side;
  wire                       last;

  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct     = 0;
  int unsigned      quiet_cycles  = 0;
  int unsigned      seat_step[fga_pkg::MaxSeatsDef];
  fork_scoreboard   sb;

  fork_grant_arbiter_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_wr_data_i  (cfg_wr_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .seat_i         (seat),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .granted_seat_o (granted_seat),
    .fork_side_o    (fork_side),
    .last_o         (last)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_n && in_valid && in_stall === 1'b0) sb.note_request(action, seat);
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      sb.check_grant(granted_seat, fork_side, last);
    end
    out_stall <= hold_active || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [fga_pkg::ActW-1:0] act,
                              input logic [fga_pkg::SeatW-1:0] seat_v);
    action   <= act;
    seat     <= seat_v;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic send_random_request();
    int unsigned               n;
    logic [fga_pkg::SeatW-1:0] s;
    logic [fga_pkg::ActW-1:0]  act;
    n = sb.ring_size();
    if ($urandom_range(99) < 80) begin
      s = fga_pkg::SeatW'($urandom_range(n - 1));
      case (seat_step[s])
        0: begin
          act = fga_pkg::ActLeft;
        end
        1: begin
          act = fga_pkg::ActRight;
        end
        default: begin
          act = fga_pkg::ActPut;
        end
      endcase
      seat_step[s] = (seat_step[s] + 1) % 3;
    end else begin
      act = fga_pkg::ActW'($urandom_range(3));
      s   = fga_pkg::SeatW'($urandom_range(fga_pkg::MaxSeatsDef - 1));
    end
    send_request(act, s);
  endtask

  task automatic wait_until_idle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_seats(input logic [fga_pkg::CfgW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk_i);
    cfg_wr_en   <= 1'b0;
    sb.set_seats(value);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_active <= 1'b0;
  endtask

  task automatic run_phase(input logic [fga_pkg::CfgW-1:0] value,
                           input int unsigned send_pct,
                           input int unsigned recv_pct, input bit pressure);
    wait_until_idle();
    write_seats(value);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    if (pressure) begin
      fork
        hold_receiver(HoldCycles);
      join_none
    end
    repeat (PhaseItems) send_random_request();
    in_valid <= 1'b0;
  endtask

  initial begin
    sb = new();
    foreach (seat_step[i]) seat_step[i] = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_request(fga_pkg::ActLeft, 0);
    send_request(fga_pkg::ActRight, 4);
    send_request(fga_pkg::ActRight, 0);
    send_request(ActNone, 1);
    send_request(fga_pkg::ActLeft, 15);
    send_request(fga_pkg::ActLeft, 1);
    send_request(fga_pkg::ActLeft, 2);
    send_request(fga_pkg::ActLeft, 3);
    send_request(fga_pkg::ActLeft, 4);
    send_request(fga_pkg::ActPut, 0);
    send_request(fga_pkg::ActPut, 3);
    repeat (QueueDepth + 1) send_request(fga_pkg::ActRight, 3);
    send_request(fga_pkg::ActPut, 2);
    send_request(fga_pkg::ActPut, 1);
    send_request(fga_pkg::ActPut, 4);
    in_valid <= 1'b0;

    // Shrinking the ring leaves the queued seat-three requests stale.
    run_phase(5'd3, 0, 0, 1'b0);
    run_phase(5'd16, 61, 0, 1'b0);
    run_phase(5'd2, 0, 61, 1'b0);
    run_phase(5'd0, 34, 34, 1'b0);
    run_phase(5'd31, 0, 0, 1'b1);
    run_phase(5'd9, 61, 0, 1'b0);
    run_phase(5'd17, 0, 61, 1'b0);
    run_phase(5'd5, 34, 34, 1'b0);

    wait_until_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+design
design/fga_pkg.sv
design/fga_ctrl.sv
design/fga_datapath.sv
design/fork_grant_arbiter_top.sv
tb/sv/tb_fork_grant_arbiter_top.sv
